@@ rtl/snc_pkg.sv @@
package snc_pkg;

  localparam int CRD_W   = 32;   // coordinate and pixel field width
  localparam int T_BITS  = 30;   // clip fraction bits
  localparam int Q_BITS  = 40;   // projected quotient bits, larger values saturate
  localparam int PIX_W   = 43;   // unsaturated pixel value width
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_U     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_V     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

  typedef struct packed {
    logic signed [CRD_W-1:0] al;
    logic signed [CRD_W-1:0] ad;
    logic signed [CRD_W-1:0] au;
    logic signed [CRD_W-1:0] bl;
    logic signed [CRD_W-1:0] bd;
    logic signed [CRD_W-1:0] bu;
    logic                    reject;
    logic                    clip_a;
    logic                    clip_b;
  } seg_t;

  // per-lane control riding along a projection divider
  typedef struct packed {
    logic reject;
    logic neg;
    logic ovf;
  } qctl_t;

endpackage

@@ rtl/snc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Requires in_rem < in_den; dividend is {in_rem, in_num}.
module snc_div #(
  parameter int QW = 40,
  parameter int DW = 32,
  parameter int SW = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [QW-1:0] vld_r;
  logic [DW-1:0] rem_r  [QW-1];
  logic [DW-1:0] den_r  [QW-1];
  logic [QW-1:0] num_r  [QW-1];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] num_i;
    logic [QW-1:0] quo_i;
    logic [SW-1:0] side_i;
    logic          vld_i;
    logic [DW:0]   trial;
    logic          fits;
    logic [DW-1:0] rem_nxt;

    if (s == 0) begin : g_first
      assign rem_i  = in_rem;
      assign den_i  = in_den;
      assign num_i  = in_num;
      assign quo_i  = '0;
      assign side_i = in_side;
      assign vld_i  = in_valid;
    end else begin : g_next
      assign rem_i  = rem_r[s-1];
      assign den_i  = den_r[s-1];
      assign num_i  = num_r[s-1];
      assign quo_i  = quo_r[s-1];
      assign side_i = side_r[s-1];
      assign vld_i  = vld_r[s-1];
    end

    assign trial   = {rem_i, num_i[QW-1]};
    assign fits    = trial >= {1'b0, den_i};
    assign rem_nxt = fits ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s]  <= {quo_i[QW-2:0], fits};
        side_r[s] <= side_i;
      end
    end

    if (s < QW-1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          den_r[s] <= den_i;
          num_r[s] <= {num_i[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

@@ rtl/segment_near_clip_project.sv @@
// Near-plane segment clipper and pinhole projector. One segment request is
// taken per clock unless the pipeline holds; its result passes one input
// register, a 30-stage divider for the clip fraction, a multiply stage and
// an add stage that move a clipped endpoint onto the near plane, a focal
// multiply stage, four parallel 40-stage dividers for the projection, a
// center add stage and the output register. The two divider chains make
// up most of the depth; each resolves one quotient bit per stage. The whole
// pipeline holds while a finished result waits on out_tready, and input is
// taken whenever the output register is empty or being drained.
module segment_near_clip_project #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_lateral, start_depth, start_up, end_lateral, end_depth, end_up
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // start_col, start_row, end_col, end_row
  output logic [127:0] out_tdata,
  // visible
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int W  = snc_pkg::CRD_W;
  localparam int PW = snc_pkg::PIX_W;
  localparam int QB = snc_pkg::Q_BITS;
  localparam int TB = snc_pkg::T_BITS;
  localparam longint NEAR_L = ((longint'(1) << FRAC_BITS) + 10) / 20;
  localparam logic signed [W-1:0]  NEAR_Q   = W'(NEAR_L);
  localparam logic signed [PW-1:0] MARGIN_Q = PW'(longint'(200) << FRAC_BITS);

  function automatic logic [W-1:0] sat32(input logic signed [PW-1:0] v);
    logic [W-1:0] res;
    if (v > $signed({{(PW-W+1){1'b0}}, {(W-1){1'b1}}})) begin
      res = {1'b0, {(W-1){1'b1}}};
    end else if (v < $signed({{(PW-W+1){1'b1}}, {(W-1){1'b0}}})) begin
      res = {1'b1, {(W-1){1'b0}}};
    end else begin
      res = v[W-1:0];
    end
    return res;
  endfunction

  // ---------------- configuration ----------------
  logic [31:0] focal_x_r, focal_y_r, center_u_r, center_v_r;
  logic [13:0] image_width_r, image_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r      <= 32'(longint'(500) << FRAC_BITS);
      focal_y_r      <= 32'(longint'(500) << FRAC_BITS);
      center_u_r     <= 32'(longint'(320) << FRAC_BITS);
      center_v_r     <= 32'(longint'(240) << FRAC_BITS);
      image_width_r  <= 14'd640;
      image_height_r <= 14'd480;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        snc_pkg::REG_FOCAL_X:      focal_x_r      <= cfg_data;
        snc_pkg::REG_FOCAL_Y:      focal_y_r      <= cfg_data;
        snc_pkg::REG_CENTER_U:     center_u_r     <= cfg_data;
        snc_pkg::REG_CENTER_V:     center_v_r     <= cfg_data;
        snc_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[13:0];
        snc_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---------------- stage 1: near test and clip divide operands ----------------
  snc_pkg::seg_t   s1_seg_nxt, s1_seg_r;
  logic            s1_v_r;
  logic [W-1:0]    s1_num_nxt, s1_den_nxt, s1_num_r, s1_den_r;
  logic signed [W:0] num_a, num_b, den_a, den_b;
  logic            a_beh, b_beh;

  always_comb begin
    s1_seg_nxt.al = $signed(in_tdata[31:0]);
    s1_seg_nxt.ad = $signed(in_tdata[63:32]);
    s1_seg_nxt.au = $signed(in_tdata[95:64]);
    s1_seg_nxt.bl = $signed(in_tdata[127:96]);
    s1_seg_nxt.bd = $signed(in_tdata[159:128]);
    s1_seg_nxt.bu = $signed(in_tdata[191:160]);
    a_beh = s1_seg_nxt.ad <= NEAR_Q;
    b_beh = s1_seg_nxt.bd <= NEAR_Q;
    s1_seg_nxt.reject = a_beh && b_beh;
    s1_seg_nxt.clip_a = a_beh && !b_beh;
    s1_seg_nxt.clip_b = b_beh && !a_beh;
    num_a = {NEAR_Q[W-1], NEAR_Q} - {s1_seg_nxt.ad[W-1], s1_seg_nxt.ad};
    num_b = {NEAR_Q[W-1], NEAR_Q} - {s1_seg_nxt.bd[W-1], s1_seg_nxt.bd};
    den_a = {s1_seg_nxt.bd[W-1], s1_seg_nxt.bd} - {s1_seg_nxt.ad[W-1], s1_seg_nxt.ad};
    den_b = {s1_seg_nxt.ad[W-1], s1_seg_nxt.ad} - {s1_seg_nxt.bd[W-1], s1_seg_nxt.bd};
    if (s1_seg_nxt.clip_a) begin
      s1_num_nxt = num_a[W-1:0];
      s1_den_nxt = den_a[W-1:0];
    end else if (s1_seg_nxt.clip_b) begin
      s1_num_nxt = num_b[W-1:0];
      s1_den_nxt = den_b[W-1:0];
    end else begin
      s1_num_nxt = '0;
      s1_den_nxt = W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_seg_r <= s1_seg_nxt;
      s1_num_r <= s1_num_nxt;
      s1_den_r <= s1_den_nxt;
    end
  end

  // ---------------- clip fraction t = (near - d_in) * 2^30 / (d_out - d_in) ----------------
  logic                          cd_v;
  logic [TB-1:0]                 cd_t;
  logic [$bits(snc_pkg::seg_t)-1:0] cd_side;
  snc_pkg::seg_t                 cd_seg;

  snc_div #(.QW(TB), .DW(W), .SW($bits(snc_pkg::seg_t))) u_clip_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s1_v_r),
    .in_rem   (s1_num_r),
    .in_num   ('0),
    .in_den   (s1_den_r),
    .in_side  (s1_seg_r),
    .out_valid(cd_v),
    .out_quo  (cd_t),
    .out_side (cd_side)
  );

  assign cd_seg = snc_pkg::seg_t'(cd_side);

  // ---------------- M1: offset products ----------------
  logic signed [W-1:0] m1_pl, m1_ql, m1_pu, m1_qu;
  logic signed [W:0]   dl, du;
  logic [W-1:0]        magl, magu;
  logic [W+TB-1:0]     m1_prl_r, m1_pru_r;
  logic                m1_negl_r, m1_negu_r, m1_v_r;
  snc_pkg::seg_t       m1_seg_r;

  always_comb begin
    m1_pl = cd_seg.clip_b ? cd_seg.bl : cd_seg.al;
    m1_ql = cd_seg.clip_b ? cd_seg.al : cd_seg.bl;
    m1_pu = cd_seg.clip_b ? cd_seg.bu : cd_seg.au;
    m1_qu = cd_seg.clip_b ? cd_seg.au : cd_seg.bu;
    dl = {m1_ql[W-1], m1_ql} - {m1_pl[W-1], m1_pl};
    du = {m1_qu[W-1], m1_qu} - {m1_pu[W-1], m1_pu};
    magl = dl[W] ? W'(-dl) : dl[W-1:0];
    magu = du[W] ? W'(-du) : du[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= cd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_seg_r  <= cd_seg;
      m1_prl_r  <= (W+TB)'(magl) * (W+TB)'(cd_t);
      m1_pru_r  <= (W+TB)'(magu) * (W+TB)'(cd_t);
      m1_negl_r <= dl[W];
      m1_negu_r <= du[W];
    end
  end

  // ---------------- M2: move the clipped endpoint onto the near plane ----------------
  logic signed [W-1:0] m2_pl, m2_pu, m2_nl, m2_nu;
  logic [W-1:0]        offl, offu;
  snc_pkg::seg_t       m2_seg_nxt, m2_seg_r;
  logic                m2_v_r;

  always_comb begin
    m2_pl = m1_seg_r.clip_b ? m1_seg_r.bl : m1_seg_r.al;
    m2_pu = m1_seg_r.clip_b ? m1_seg_r.bu : m1_seg_r.au;
    offl  = m1_prl_r[W+TB-1:TB];
    offu  = m1_pru_r[W+TB-1:TB];
    m2_nl = m1_negl_r ? m2_pl - $signed(offl) : m2_pl + $signed(offl);
    m2_nu = m1_negu_r ? m2_pu - $signed(offu) : m2_pu + $signed(offu);
    m2_seg_nxt = m1_seg_r;
    if (m1_seg_r.clip_a) begin
      m2_seg_nxt.al = m2_nl;
      m2_seg_nxt.au = m2_nu;
      m2_seg_nxt.ad = NEAR_Q;
    end else if (m1_seg_r.clip_b) begin
      m2_seg_nxt.bl = m2_nl;
      m2_seg_nxt.bu = m2_nu;
      m2_seg_nxt.bd = NEAR_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_seg_r <= m2_seg_nxt;
    end
  end

  // ---------------- P1: focal products on magnitudes ----------------
  // lane order: start col, start row, end col, end row
  logic signed [W-1:0] crd [4];
  logic [W-1:0]        crd_mag [4];
  logic [31:0]         lane_f [4];
  logic [2*W-1:0]      p1_prod_r [4];
  logic [3:0]          p1_neg_r;
  logic [W-1:0]        p1_da_r, p1_db_r;
  logic                p1_rej_r, p1_v_r;

  always_comb begin
    crd[0] = m2_seg_r.al;
    crd[1] = m2_seg_r.au;
    crd[2] = m2_seg_r.bl;
    crd[3] = m2_seg_r.bu;
    lane_f[0] = focal_x_r;
    lane_f[1] = focal_y_r;
    lane_f[2] = focal_x_r;
    lane_f[3] = focal_y_r;
    for (int k = 0; k < 4; k++) begin
      crd_mag[k] = crd[k][W-1] ? W'(-crd[k]) : crd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        p1_prod_r[k] <= (2*W)'(lane_f[k]) * (2*W)'(crd_mag[k]);
        p1_neg_r[k]  <= crd[k][W-1];
      end
      p1_da_r  <= m2_seg_r.ad;
      p1_db_r  <= m2_seg_r.bd;
      p1_rej_r <= m2_seg_r.reject;
    end
  end

  // ---------------- projection dividers ----------------
  logic [3:0]    pd_v;
  logic [QB-1:0] pd_q [4];
  snc_pkg::qctl_t pd_ctl [4];

  for (genvar k = 0; k < 4; k++) begin : g_proj
    logic [W-1:0]       den;
    logic [2*W-QB-1:0]  hi;
    logic               ovf;
    snc_pkg::qctl_t     ctl_in;
    logic [$bits(snc_pkg::qctl_t)-1:0] ctl_out;

    assign den = (k < 2) ? p1_da_r : p1_db_r;
    assign hi  = p1_prod_r[k][2*W-1:QB];
    // quotient at or above 2^40 lands far outside any bound and saturates
    assign ovf = W'(hi) >= den;
    assign ctl_in = '{reject: p1_rej_r, neg: p1_neg_r[k], ovf: ovf};

    snc_div #(.QW(QB), .DW(W), .SW($bits(snc_pkg::qctl_t))) u_proj_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (p1_v_r),
      .in_rem   (ovf ? '0 : W'(hi)),
      .in_num   (p1_prod_r[k][QB-1:0]),
      .in_den   (den),
      .in_side  (ctl_in),
      .out_valid(pd_v[k]),
      .out_quo  (pd_q[k]),
      .out_side (ctl_out)
    );

    assign pd_ctl[k] = snc_pkg::qctl_t'(ctl_out);
  end

  // ---------------- F1: add to (columns) or subtract from (rows) principal point ----------------
  logic [QB-1:0]        qm [4];
  logic signed [PW-1:0] sq [4];
  logic signed [PW-1:0] pix_nxt [4];
  logic signed [PW-1:0] f1_pix_r [4];
  logic                 f1_rej_r, f1_v_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qm[k] = pd_ctl[k].ovf ? '1 : pd_q[k];
      sq[k] = pd_ctl[k].neg ? -$signed(PW'(qm[k])) : $signed(PW'(qm[k]));
    end
    pix_nxt[0] = $signed(PW'(center_u_r)) + sq[0];
    pix_nxt[1] = $signed(PW'(center_v_r)) - sq[1];
    pix_nxt[2] = $signed(PW'(center_u_r)) + sq[2];
    pix_nxt[3] = $signed(PW'(center_v_r)) - sq[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= &pd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        f1_pix_r[k] <= pix_nxt[k];
      end
      f1_rej_r <= pd_ctl[0].reject | pd_ctl[1].reject | pd_ctl[2].reject | pd_ctl[3].reject;
    end
  end

  // ---------------- output: bounds test and saturation ----------------
  logic signed [PW-1:0] w_lim, h_lim;
  logic                 off_img, vis_nxt;
  logic [127:0]         data_nxt, out_data_r;
  logic                 out_vis_r;

  always_comb begin
    w_lim = $signed(PW'(image_width_r) << FRAC_BITS) + MARGIN_Q;
    h_lim = $signed(PW'(image_height_r) << FRAC_BITS) + MARGIN_Q;
    off_img = (f1_pix_r[0] < -MARGIN_Q && f1_pix_r[2] < -MARGIN_Q) ||
              (f1_pix_r[0] > w_lim && f1_pix_r[2] > w_lim) ||
              (f1_pix_r[1] < -MARGIN_Q && f1_pix_r[3] < -MARGIN_Q) ||
              (f1_pix_r[1] > h_lim && f1_pix_r[3] > h_lim);
    vis_nxt = !f1_rej_r && !off_img;
    if (vis_nxt) begin
      data_nxt = {sat32(f1_pix_r[3]), sat32(f1_pix_r[2]),
                  sat32(f1_pix_r[1]), sat32(f1_pix_r[0])};
    end else begin
      data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vis_r  <= vis_nxt;
      out_data_r <= data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_vis_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("rejected segment carries nonzero pixels");

  a_clip_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (m2_v_r && m2_seg_r.clip_a) |-> (m2_seg_r.ad == NEAR_Q))
    else $error("clipped start endpoint not on near plane");

  a_one_clip: assert property (@(posedge clk) disable iff (!rst_n)
    m1_v_r |-> !(m1_seg_r.clip_a && m1_seg_r.clip_b))
    else $error("both endpoints marked for clipping");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
`endif

endmodule

@@ test/segment_check.sv @@
`timescale 1ns / 100ps
module segment_check (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [191:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic         out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  localparam int FRAC = 16;
  localparam longint NEAR = ((64'sd1 <<< FRAC) + 10) / 20;
  localparam longint MARGIN = 64'sd200 <<< FRAC;

  typedef struct packed {
    logic        visible;
    logic [31:0] start_col;
    logic [31:0] start_row;
    logic [31:0] end_col;
    logic [31:0] end_row;
  } pixel_seg_t;

  logic [31:0] fx, fy, cu, cv;
  logic [13:0] iw, ih;
  pixel_seg_t projections[$];

  function automatic longint slide(longint p, longint q, logic [63:0] t);
    longint d;
    logic [63:0] mag, off;
    begin
      d = q - p;
      mag = d < 0 ? -d : d;
      off = (mag * t) >> 30;
      return d < 0 ? p - longint'(off) : p + longint'(off);
    end
  endfunction

  function automatic longint perspective(logic [31:0] f, longint x, longint depth);
    logic [63:0] mag, q;
    begin
      mag = x < 0 ? -x : x;
      q = (64'(f) * mag) / 64'(depth);
      return x < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic pixel_seg_t project_segment(logic [191:0] d);
    longint al, ad, au, bl, bd, bu, ua, va, ub, vb, w, h;
    logic [63:0] t;
    pixel_seg_t r;
    begin
      al = longint'($signed(d[31:0]));
      ad = longint'($signed(d[63:32]));
      au = longint'($signed(d[95:64]));
      bl = longint'($signed(d[127:96]));
      bd = longint'($signed(d[159:128]));
      bu = longint'($signed(d[191:160]));
      r = '0;
      if (ad <= NEAR && bd <= NEAR) return r;
      if (ad <= NEAR) begin
        t = (64'(NEAR - ad) << 30) / 64'(bd - ad);
        al = slide(al, bl, t);
        au = slide(au, bu, t);
        ad = NEAR;
      end else if (bd <= NEAR) begin
        t = (64'(NEAR - bd) << 30) / 64'(ad - bd);
        bl = slide(bl, al, t);
        bu = slide(bu, au, t);
        bd = NEAR;
      end
      ua = longint'(cu) + perspective(fx, al, ad);
      va = longint'(cv) - perspective(fy, au, ad);
      ub = longint'(cu) + perspective(fx, bl, bd);
      vb = longint'(cv) - perspective(fy, bu, bd);
      w = (longint'(iw) <<< FRAC) + MARGIN;
      h = (longint'(ih) <<< FRAC) + MARGIN;
      if ((ua < -MARGIN && ub < -MARGIN) || (ua > w && ub > w) ||
          (va < -MARGIN && vb < -MARGIN) || (va > h && vb > h))
        return r;
      r.visible = 1'b1;
      r.start_col = clamp32(ua);
      r.start_row = clamp32(va);
      r.end_col = clamp32(ub);
      r.end_row = clamp32(vb);
      return r;
    end
  endfunction

  function automatic void compare(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s expected %h got %h", name, exp, act);
      fail_count++;
    end
  endfunction

  assign pending = projections.size();

  always @(posedge clk) begin
    pixel_seg_t e;
    if (!rst_n) begin
      fx <= 32'd32768000;
      fy <= 32'd32768000;
      cu <= 32'd20971520;
      cv <= 32'd15728640;
      iw <= 14'd640;
      ih <= 14'd480;
      fail_count <= 0;
      projections.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          snc_pkg::REG_FOCAL_X:      fx <= cfg_data;
          snc_pkg::REG_FOCAL_Y:      fy <= cfg_data;
          snc_pkg::REG_CENTER_U:     cu <= cfg_data;
          snc_pkg::REG_CENTER_V:     cv <= cfg_data;
          snc_pkg::REG_IMAGE_WIDTH:  iw <= cfg_data[13:0];
          snc_pkg::REG_IMAGE_HEIGHT: ih <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) projections = {projections, project_segment(in_tdata)};
      if (out_tvalid && out_tready) begin
        if (projections.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = projections.pop_front();
          compare("visible", 32'(e.visible), 32'(out_tuser));
          compare("start_col", e.start_col, out_tdata[31:0]);
          compare("start_row", e.start_row, out_tdata[63:32]);
          compare("end_col", e.end_col, out_tdata[95:64]);
          compare("end_row", e.end_row, out_tdata[127:96]);
        end
      end
    end
  end
endmodule

@@ test/tb_segment_near_clip_project.sv @@
`timescale 1ns / 100ps
module tb_segment_near_clip_project;

  localparam int LATENCY = 76;
  localparam int NEAR = 3277;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [191:0] in_tdata = '0;
  logic out_tvalid, out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count, pending;
  int idle_cycles = 0;
  int hold_off = 0;
  bit stim_done = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_near_clip_project DUT (.*);
  segment_check u_check (.*);

  // receiver: random stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) && stim_done);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_segment(logic [191:0] d);
    in_tdata <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1200000)) - 600000);
      2: return 32'($urandom_range(0, 6000));
      3: return {$urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000};
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [31:0] rnd_depth();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8000)) - 4000 + NEAR);
      2: return 32'(NEAR);
      default: return 32'($urandom_range(100000, 3000000));
    endcase
  endfunction

  function automatic logic [191:0] rnd_segment();
    return {rnd_coord(), rnd_depth(), rnd_coord(), rnd_coord(), rnd_depth(), rnd_coord()};
  endfunction

  task automatic random_burst(int count);
    int n;
    n = 0;
    while (n < count) begin
      repeat ($urandom_range(1, 20)) begin
        if (n < count) begin
          send_segment(rnd_segment());
          n++;
        end
      end
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: {bu, bd, bl, au, ad, al}
    send_segment({32'sd65536, 32'sd655360, 32'sd65536, -32'sd65536, 32'sd327680, -32'sd65536});
    send_segment({32'sd0, 32'(NEAR), 32'sd0, 32'sd0, 32'(NEAR), 32'sd0});
    send_segment({32'sd65536, 32'sd655360, 32'sd131072, 32'sd0, 32'(NEAR), 32'sd0});
    send_segment({32'sd0, -32'sd65536, 32'sd0, 32'sd65536, 32'sd655360, 32'sd65536});
    send_segment({32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                  32'h80000000});
    send_segment({32'sd0, 32'sd3278, 32'h7fffffff, 32'sd0, 32'sd3278, 32'h7fffffff});
    send_segment({32'h80000000, 32'sd3278, 32'sd0, 32'h7fffffff, 32'sd3278, 32'sd0});
    send_segment({32'sd0, 32'sd6553600, 32'sd99999999, 32'sd0, 32'sd6553600, 32'sd88888888});
    send_segment({32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                  32'hffffffff});
    send_segment({32'sd0, 32'h7fffffff, 32'sd0, 32'sd0, 32'h80000000, 32'sd0});
    drain();

    random_burst(250);
    // long receiver hold-off while requests keep coming
    hold_off = 400;
    random_burst(150);
    drain();

    write_reg(snc_pkg::REG_FOCAL_X, 32'd1);
    write_reg(snc_pkg::REG_FOCAL_Y, 32'hffffffff);
    write_reg(snc_pkg::REG_CENTER_U, 32'd0);
    write_reg(snc_pkg::REG_CENTER_V, 32'hffffffff);
    write_reg(snc_pkg::REG_IMAGE_WIDTH, 32'd1);
    write_reg(snc_pkg::REG_IMAGE_HEIGHT, 32'd8192);
    random_burst(150);
    drain();

    write_reg(snc_pkg::REG_FOCAL_X, 32'hffffffff);
    write_reg(snc_pkg::REG_FOCAL_Y, 32'd0);
    write_reg(snc_pkg::REG_CENTER_U, 32'hffffffff);
    write_reg(snc_pkg::REG_CENTER_V, 32'd0);
    write_reg(snc_pkg::REG_IMAGE_WIDTH, 32'd8192);
    write_reg(snc_pkg::REG_IMAGE_HEIGHT, 32'd1);
    write_reg(3'd7, 32'h12345678);
    random_burst(150);
    drain();

    write_reg(snc_pkg::REG_FOCAL_X, 32'd52428800);
    write_reg(snc_pkg::REG_FOCAL_Y, 32'd39321600);
    write_reg(snc_pkg::REG_CENTER_U, 32'd41943040);
    write_reg(snc_pkg::REG_CENTER_V, 32'd31457280);
    write_reg(snc_pkg::REG_IMAGE_WIDTH, 32'd1280);
    write_reg(snc_pkg::REG_IMAGE_HEIGHT, 32'd960);
    random_burst(200);
    drain();
    stim_done = 1;

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ segment_near_clip_project.f @@
rtl/snc_pkg.sv
rtl/snc_div.sv
rtl/segment_near_clip_project.sv
test/segment_check.sv
test/tb_segment_near_clip_project.sv
